@@ rtl/core/decimal_seven_segment_writer_core_assert.svh @@
// Assertion helpers shared by the core files.
`ifndef DECIMAL_SEVEN_SEGMENT_WRITER_CORE_ASSERT_SVH
`define DECIMAL_SEVEN_SEGMENT_WRITER_CORE_ASSERT_SVH

// Check that a condition implies a property in the same cycle.
`define DSSW_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dssw check failed in the same cycle");

// Check that a condition implies a property in the next cycle.
`define DSSW_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dssw check failed one cycle later");

`endif

@@ rtl/core/dssw_pkg.sv @@
package dssw_pkg;

  // Segment memory layout
  localparam int BASE_ADDRESS = 145;
  localparam int DIGIT_COUNT  = 10;
  localparam int CNT_W        = $clog2(DIGIT_COUNT);
  localparam logic [7:0] ADDR_BASE = 8'(BASE_ADDRESS % 256);

  // Fixed patterns for the whole-memory commands
  localparam logic [7:0] CLEAR_PATTERN = 8'h00;
  localparam logic [7:0] FILL_PATTERN  = 8'hFF;

  // Division by ten: q = (n * 52429) >> 19, exact for all 16-bit n
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Command codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_DIGIT  = 2'd2;
  localparam logic [1:0] ACT_NUMBER = 2'd3;

  // Classified command as held in the queue
  typedef struct packed {
    logic [1:0]       action;
    logic [CNT_W-1:0] offset;
    logic [7:0]       pattern;
    logic [15:0]      number;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Seven-segment pattern of a decimal digit; non-digits map to blank
  function automatic logic [7:0] seg_pattern(input logic [3:0] dig);
    logic [7:0] pat;
    unique case (dig)
      4'd0:    pat = 8'd95;
      4'd1:    pat = 8'd6;
      4'd2:    pat = 8'd107;
      4'd3:    pat = 8'd47;
      4'd4:    pat = 8'd54;
      4'd5:    pat = 8'd61;
      4'd6:    pat = 8'd125;
      4'd7:    pat = 8'd39;
      4'd8:    pat = 8'd127;
      4'd9:    pat = 8'd63;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

@@ rtl/core/dssw_front.sv @@
module dssw_front import dssw_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  position,
  input  logic [3:0]  digit,
  input  logic [15:0] number,
  input  q_stat_t     qstat,
  output logic        push,
  output cmd_t        cmd
);

  logic       keep;
  logic [4:0] pos_off;

  // Take a transaction whenever the queue has room
  assign in_ready = !qstat.full;

  // Drop show-digit commands that would write nothing
  assign pos_off = {1'b0, position} + 5'd1;
  always_comb begin
    keep = 1'b1;
    if (action == ACT_DIGIT) begin
      keep = (digit <= 4'd9) && (pos_off < 5'(DIGIT_COUNT));
    end
  end

  assign push = in_valid && in_ready && keep;

  // Build the queue entry
  always_comb begin
    cmd.action  = action;
    cmd.offset  = CNT_W'(pos_off);
    cmd.pattern = seg_pattern(digit);
    cmd.number  = number;
  end

endmodule

@@ rtl/core/dssw_queue.sv @@
module dssw_queue import dssw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    wr_cmd,
  input  logic    pop,
  output cmd_t    rd_cmd,
  output q_stat_t qstat
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_cmd      = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/dssw_back.sv @@
module dssw_back import dssw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  q_stat_t    qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] address,
  output logic [7:0] segment_byte,
  output logic       last
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FILL  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_NUM   = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [15:0]      n, n_next;
  logic [7:0]       pat, pat_next;
  logic             num_pend, num_pend_next;

  logic        advance;
  logic        emit;
  logic [7:0]  e_addr;
  logic [7:0]  e_seg;
  logic        e_last;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem16;
  logic        cnt_end;
  logic        num_end;

  assign advance = !out_valid || out_ready;

  // One division-by-ten step on the remaining number
  assign prod    = 32'(n) * DIV10_MUL;
  assign quot    = 16'(prod >> DIV10_SHIFT);
  assign rem16   = n - (quot * 16'd10);
  assign cnt_end = (cnt == CNT_W'(DIGIT_COUNT - 1));
  assign num_end = (quot == 16'd0) ||
                   (({1'b0, cnt} + (CNT_W+1)'(2)) >= (CNT_W+1)'(DIGIT_COUNT));

  // Sequence writes for the current command
  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    n_next        = n;
    pat_next      = pat;
    num_pend_next = num_pend;
    pop           = 1'b0;
    emit          = 1'b0;
    e_addr        = ADDR_BASE + 8'(cnt);
    e_seg         = pat;
    e_last        = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (!qstat.empty) begin
          pop           = 1'b1;
          cnt_next      = '0;
          n_next        = cmd.number;
          num_pend_next = 1'b0;
          unique case (cmd.action)
            ACT_CLEAR: begin
              phase_next = PH_FILL;
              pat_next   = CLEAR_PATTERN;
            end
            ACT_FILL: begin
              phase_next = PH_FILL;
              pat_next   = FILL_PATTERN;
            end
            ACT_DIGIT: begin
              phase_next = PH_DIGIT;
              cnt_next   = cmd.offset;
              pat_next   = cmd.pattern;
            end
            ACT_NUMBER: begin
              phase_next    = PH_FILL;
              pat_next      = CLEAR_PATTERN;
              num_pend_next = 1'b1;
            end
          endcase
        end
      end
      PH_FILL: begin
        if (advance) begin
          emit   = 1'b1;
          e_last = cnt_end && !num_pend;
          if (cnt_end) begin
            cnt_next   = '0;
            phase_next = num_pend ? PH_NUM : PH_IDLE;
          end else begin
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
      PH_DIGIT: begin
        if (advance) begin
          emit       = 1'b1;
          e_last     = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_NUM: begin
        e_addr = ADDR_BASE + 8'(cnt) + 8'd1;
        e_seg  = seg_pattern(rem16[3:0]);
        if (advance) begin
          emit   = 1'b1;
          e_last = num_end;
          if (num_end) begin
            phase_next = PH_IDLE;
          end else begin
            n_next   = quot;
            cnt_next = cnt + CNT_W'(1);
          end
        end
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      num_pend <= 1'b0;
    end else begin
      phase    <= phase_next;
      num_pend <= num_pend_next;
    end
    cnt <= cnt_next;
    n   <= n_next;
    pat <= pat_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
    if (advance && emit) begin
      address      <= e_addr;
      segment_byte <= e_seg;
      last         <= e_last;
    end
  end

endmodule

@@ rtl/core/decimal_seven_segment_writer_core.sv @@
// Decimal seven-segment writer: turns clear, fill, show-digit and show-number
// commands into byte writes for a ten-byte segment memory at address 145.
// Commands are taken into a two-entry queue, so in_ready drops only while
// that queue is full; a show-digit command with a digit above nine or a
// position above eight is taken and produces no write. The back end takes
// a command from the queue in its idle state and then gives one write
// per cycle while out_ready is high: clear and fill write all ten bytes,
// show-digit one byte, and show-number a clear of all ten plus one write per
// decimal digit, each digit coming from one divide-by-ten step done as a
// reciprocal multiply. The final write of each command carries last.
module decimal_seven_segment_writer_core import dssw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  position,
  input  logic [3:0]  digit,
  input  logic [15:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  address,
  output logic [7:0]  segment_byte,
  output logic        last
);

`include "decimal_seven_segment_writer_core_assert.svh"

  q_stat_t qstat;
  cmd_t    wr_cmd;
  cmd_t    rd_cmd;
  logic    push;
  logic    pop;

  // Accept and classify commands
  dssw_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .position (position),
    .digit    (digit),
    .number   (number),
    .qstat    (qstat),
    .push     (push),
    .cmd      (wr_cmd)
  );

  // Buffer commands between the two sides
  dssw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .qstat  (qstat)
  );

  // Generate memory writes
  dssw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (rd_cmd),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .address      (address),
    .segment_byte (segment_byte),
    .last         (last)
  );

  // Every write lands inside the segment memory
  `DSSW_ASSERT_NOW(a_addr_range, out_valid, (8'(address - ADDR_BASE) < 8'(DIGIT_COUNT)))
  // Never push into a full queue or pop an empty one
  `DSSW_ASSERT_NOW(a_no_overflow, push, !qstat.full)
  `DSSW_ASSERT_NOW(a_no_underflow, pop, !qstat.empty)
  // A pop with no push frees a slot, so the next transaction can be taken
  `DSSW_ASSERT_NEXT(a_pop_frees, (pop && !push), in_ready)

endmodule
